### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the deframer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hdl/lfpd_pkg.sv
// ----------------------------------------------------------------------------
// Deframer package
// Types, constants and register indexes shared by the deframer files.
// ----------------------------------------------------------------------------
package lfpd_pkg;

  localparam int MAX_PAYLOAD = 64;
  localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
  localparam int COUNT_W     = $clog2(MAX_PAYLOAD + 1);
  localparam int CFG_IDX_W   = 8;

  typedef logic [7:0]           byte_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [COUNT_W-1:0]   count_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_FIRST_HEADER  = 8'd0;
  localparam cfg_idx_t REG_SECOND_HEADER = 8'd1;
  localparam cfg_idx_t REG_FIRST_TAIL    = 8'd2;
  localparam cfg_idx_t REG_SECOND_TAIL   = 8'd3;

  localparam byte_t FIRST_HEADER_RST  = 8'd170;
  localparam byte_t SECOND_HEADER_RST = 8'd85;
  localparam byte_t FIRST_TAIL_RST    = 8'd13;
  localparam byte_t SECOND_TAIL_RST   = 8'd10;

  typedef enum logic [2:0] {
    PH_HEAD1,
    PH_HEAD2,
    PH_LEN,
    PH_DATA,
    PH_TAIL1,
    PH_TAIL2,
    PH_EMIT_RD,
    PH_EMIT_WR
  } phase_t;

endpackage

### hdl/lfpd_ifs.sv
// ----------------------------------------------------------------------------
// Deframer channel interfaces
// Valid/ready channels for received bytes, payload results and register writes.
// ----------------------------------------------------------------------------
interface lfpd_rx_if;
  logic            valid;
  logic            ready;
  lfpd_pkg::byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface lfpd_out_if;
  logic            valid;
  logic            ready;
  lfpd_pkg::byte_t payload_byte;
  logic            last_of_frame;
  logic            empty_frame;

  modport source (output valid, output payload_byte, output last_of_frame,
                  output empty_frame, input ready);
  modport sink (input valid, input payload_byte, input last_of_frame,
                input empty_frame, output ready);
endinterface

interface lfpd_cfg_if;
  logic               valid;
  logic               ready;
  lfpd_pkg::cfg_idx_t index;
  lfpd_pkg::byte_t    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/lfpd_payload_ram.sv
// ----------------------------------------------------------------------------
// Payload RAM
// Simple dual-port payload buffer with one write port and a registered read.
// ----------------------------------------------------------------------------
module lfpd_payload_ram (
  input  logic            clk,
  input  logic            we,
  input  lfpd_pkg::addr_t waddr,
  input  lfpd_pkg::byte_t wdata,
  input  lfpd_pkg::addr_t raddr,
  output lfpd_pkg::byte_t rdata
);
  import lfpd_pkg::*;

  byte_t mem [MAX_PAYLOAD];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hdl/length_framed_packet_deframer_core.sv
// ----------------------------------------------------------------------------
// Length-framed packet deframer
// Parses header, length, payload and tail bytes and releases checked payloads.
// ----------------------------------------------------------------------------
// While a frame is received the block takes one byte per cycle, but the second
// tail byte waits for a free output register. Payload bytes go into a 64-entry
// RAM. When both tail bytes match, the payload is released byte by byte: a read
// state reads the registered RAM, a write state loads the output register and
// waits out output stalls; the input is held off until the last byte is loaded.
// A zero-length frame releases its single empty result on the second tail byte.
`include "assert_macros.svh"

module length_framed_packet_deframer_core (
  input logic        clk,
  input logic        rst,
  lfpd_rx_if.sink    rx,
  lfpd_out_if.source payload,
  lfpd_cfg_if.sink   cfg
);
  import lfpd_pkg::*;

  byte_t  first_header_byte;
  byte_t  second_header_byte;
  byte_t  first_tail_byte;
  byte_t  second_tail_byte;

  phase_t phase;
  phase_t phase_next;
  count_t payload_count;
  count_t announced_length;
  addr_t  rd_idx;

  logic   out_valid;
  byte_t  out_byte;
  logic   out_last;
  logic   out_empty;

  logic   rx_ready;
  logic   accept;
  logic   slot;
  logic   count_clr;
  logic   count_inc;
  logic   len_load;
  logic   idx_clr;
  logic   idx_inc;
  logic   load_empty;
  logic   load_byte;
  logic   is_last;
  count_t count_plus;
  byte_t  rd_data;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_header_byte  <= FIRST_HEADER_RST;
      second_header_byte <= SECOND_HEADER_RST;
      first_tail_byte    <= FIRST_TAIL_RST;
      second_tail_byte   <= SECOND_TAIL_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_FIRST_HEADER:  first_header_byte  <= cfg.data;
        REG_SECOND_HEADER: second_header_byte <= cfg.data;
        REG_FIRST_TAIL:    first_tail_byte    <= cfg.data;
        REG_SECOND_TAIL:   second_tail_byte   <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  assign slot       = !out_valid || payload.ready;
  assign accept     = rx.valid && rx_ready;
  assign count_inc  = (phase == PH_DATA) && accept && (payload_count < COUNT_W'(MAX_PAYLOAD));
  assign count_plus = payload_count + COUNT_W'(count_inc);
  assign is_last    = (COUNT_W'(rd_idx) + COUNT_W'(1)) == payload_count;

  always_comb begin
    phase_next = phase;
    rx_ready   = 1'b1;
    count_clr  = 1'b0;
    len_load   = 1'b0;
    idx_clr    = 1'b0;
    idx_inc    = 1'b0;
    load_empty = 1'b0;
    load_byte  = 1'b0;
    case (phase)
      PH_HEAD1: begin
        if (accept && (rx.rx_byte == first_header_byte)) begin
          phase_next = PH_HEAD2;
          count_clr  = 1'b1;
        end
      end
      PH_HEAD2: begin
        if (accept) begin
          phase_next = (rx.rx_byte == second_header_byte) ? PH_LEN : PH_HEAD1;
        end
      end
      PH_LEN: begin
        if (accept) begin
          if (rx.rx_byte <= 8'(MAX_PAYLOAD)) begin
            len_load   = 1'b1;
            count_clr  = 1'b1;
            phase_next = (rx.rx_byte == 8'd0) ? PH_TAIL1 : PH_DATA;
          end else begin
            phase_next = PH_HEAD1;
          end
        end
      end
      PH_DATA: begin
        if (accept && (count_plus >= announced_length)) begin
          phase_next = PH_TAIL1;
        end
      end
      PH_TAIL1: begin
        if (accept) begin
          phase_next = (rx.rx_byte == first_tail_byte) ? PH_TAIL2 : PH_HEAD1;
        end
      end
      PH_TAIL2: begin
        rx_ready = slot;
        if (accept) begin
          phase_next = PH_HEAD1;
          if (rx.rx_byte == second_tail_byte) begin
            if (payload_count == '0) begin
              load_empty = 1'b1;
            end else begin
              phase_next = PH_EMIT_RD;
              idx_clr    = 1'b1;
            end
          end
        end
      end
      PH_EMIT_RD: begin
        rx_ready   = 1'b0;
        phase_next = PH_EMIT_WR;
      end
      PH_EMIT_WR: begin
        rx_ready = 1'b0;
        if (slot) begin
          load_byte = 1'b1;
          if (is_last) begin
            phase_next = PH_HEAD1;
          end else begin
            idx_inc    = 1'b1;
            phase_next = PH_EMIT_RD;
          end
        end
      end
      default: begin
        phase_next = PH_HEAD1;
      end
    endcase
  end

  assign rx.ready = rx_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HEAD1;
      payload_count    <= '0;
      announced_length <= '0;
      rd_idx           <= '0;
      out_valid        <= 1'b0;
    end else begin
      phase <= phase_next;
      if (count_clr) begin
        payload_count <= '0;
      end else begin
        payload_count <= count_plus;
      end
      if (len_load) begin
        announced_length <= COUNT_W'(rx.rx_byte);
      end
      if (idx_clr) begin
        rd_idx <= '0;
      end else if (idx_inc) begin
        rd_idx <= rd_idx + ADDR_W'(1);
      end
      if (load_empty || load_byte) begin
        out_valid <= 1'b1;
      end else if (payload.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_empty) begin
      out_byte  <= '0;
      out_last  <= 1'b1;
      out_empty <= 1'b1;
    end else if (load_byte) begin
      out_byte  <= rd_data;
      out_last  <= is_last;
      out_empty <= 1'b0;
    end
  end

  lfpd_payload_ram u_ram (
    .clk   (clk),
    .we    (count_inc),
    .waddr (payload_count[ADDR_W-1:0]),
    .wdata (rx.rx_byte),
    .raddr (rd_idx),
    .rdata (rd_data)
  );

  assign payload.valid         = out_valid;
  assign payload.payload_byte  = out_byte;
  assign payload.last_of_frame = out_last;
  assign payload.empty_frame   = out_empty;

  `ASSERT_SAME(a_no_rx_while_emit, clk, rst,
    (phase == PH_EMIT_RD) || (phase == PH_EMIT_WR), !rx.ready)
  `ASSERT_SAME(a_count_bounded, clk, rst, 1'b1,
    payload_count <= COUNT_W'(MAX_PAYLOAD))
  `ASSERT_SAME(a_empty_is_last, clk, rst,
    payload.valid && payload.empty_frame, payload.last_of_frame)
  `ASSERT_NEXT(a_rd_then_wr, clk, rst, phase == PH_EMIT_RD, phase == PH_EMIT_WR)

endmodule
